// File: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest unit.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int TotalWidth = 61;

   localparam logic [31:0] IvA = 32'h67452301;
   localparam logic [31:0] IvB = 32'hefcdab89;
   localparam logic [31:0] IvC = 32'h98badcfe;
   localparam logic [31:0] IvD = 32'h10325476;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthFill = 6'd56;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       put;        // write put_byte at the fill position
      logic [7:0] put_byte;
      logic       count;      // add one to the byte total
      logic       load_work;  // copy chain words into work words
      logic       round;      // run one round
      logic       fold;       // add work words into chain words
      logic       put_length; // write the bit length into words 14 and 15
      logic       rearm;      // restore the initial vector, clear counts
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [5:0] fill;
      logic [5:0] step;
   } status_type;

   function automatic logic [31:0] sine(input logic [5:0] n);
      logic [31:0] t [64];
      t = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[n];
   endfunction

   // Rotate amount for a round.
   function automatic logic [4:0] shift(input logic [5:0] n);
      logic [4:0] s;
      case (n[5:4])
         2'd0: begin
            case (n[1:0])
               2'd0: s = 5'd7;
               2'd1: s = 5'd12;
               2'd2: s = 5'd17;
               default: s = 5'd22;
            endcase
         end
         2'd1: begin
            case (n[1:0])
               2'd0: s = 5'd5;
               2'd1: s = 5'd9;
               2'd2: s = 5'd14;
               default: s = 5'd20;
            endcase
         end
         2'd2: begin
            case (n[1:0])
               2'd0: s = 5'd4;
               2'd1: s = 5'd11;
               2'd2: s = 5'd16;
               default: s = 5'd23;
            endcase
         end
         default: begin
            case (n[1:0])
               2'd0: s = 5'd6;
               2'd1: s = 5'd10;
               2'd2: s = 5'd15;
               default: s = 5'd21;
            endcase
         end
      endcase
      return s;
   endfunction

   // Message word used by a round.
   function automatic logic [3:0] word_sel(input logic [5:0] n);
      logic [3:0] g;
      logic [7:0] p;
      p = '0;
      case (n[5:4])
         2'd0: g = n[3:0];
         2'd1: begin
            p = 8'({2'b0, n} * 8'd5 + 8'd1);
            g = p[3:0];
         end
         2'd2: begin
            p = 8'({2'b0, n} * 8'd3 + 8'd5);
            g = p[3:0];
         end
         default: begin
            p = 8'({2'b0, n} * 8'd7);
            g = p[3:0];
         end
      endcase
      return g;
   endfunction

endpackage

// File: sv/md5_datapath.sv
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, byte counter, round registers and chaining words.
// ----------------------------------------------------------------------------
module md5_datapath (
   input  logic                clock,
   input  logic                reset,
   input  md5_pkg::cmd_type    cmd,
   output md5_pkg::status_type status,
   output logic [31:0]         chain_a,
   output logic [31:0]         chain_b,
   output logic [31:0]         chain_c,
   output logic [31:0]         chain_d
);

   logic [31:0] block_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [31:0] ca_in, cb_in, cc_in, cd_in;
   logic [md5_pkg::TotalWidth-1:0] total_ff, total_in;
   logic [5:0] fill_ff, fill_in, step_ff, step_in;
   logic [31:0] f, mix, rot, msg;
   logic [63:0] bits;
   logic [4:0] sh;

   assign bits = {total_ff, 3'b000};

   // One MD5 round on the work words.
   always_comb begin
      case (step_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      msg = block_ff[md5_pkg::word_sel(step_ff)];
      sh = md5_pkg::shift(step_ff);
      mix = a_ff + f + md5_pkg::sine(step_ff) + msg;
      rot = (mix << sh) | (mix >> (6'd32 - {1'b0, sh}));
   end

   // Next values of the datapath registers.
   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      ca_in = ca_ff; cb_in = cb_ff; cc_in = cc_ff; cd_in = cd_ff;
      total_in = total_ff;
      fill_in = fill_ff;
      step_in = step_ff;
      if (cmd.put || cmd.put_length) begin
         fill_in = cmd.put_length ? 6'd0 : fill_ff + 6'd1;
      end
      if (cmd.count) begin
         total_in = total_ff + 1'b1;
      end
      if (cmd.load_work) begin
         a_in = ca_ff; b_in = cb_ff; c_in = cc_ff; d_in = cd_ff;
         step_in = '0;
      end
      if (cmd.round) begin
         a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
         step_in = step_ff + 6'd1;
      end
      if (cmd.fold) begin
         ca_in = ca_ff + a_ff; cb_in = cb_ff + b_ff;
         cc_in = cc_ff + c_ff; cd_in = cd_ff + d_ff;
      end
      if (cmd.rearm) begin
         ca_in = md5_pkg::IvA; cb_in = md5_pkg::IvB;
         cc_in = md5_pkg::IvC; cd_in = md5_pkg::IvD;
         total_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
         ca_ff <= md5_pkg::IvA; cb_ff <= md5_pkg::IvB;
         cc_ff <= md5_pkg::IvC; cd_ff <= md5_pkg::IvD;
         total_ff <= '0;
         fill_ff <= '0;
         step_ff <= '0;
      end else begin
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
         ca_ff <= ca_in; cb_ff <= cb_in; cc_ff <= cc_in; cd_ff <= cd_in;
         total_ff <= total_in;
         fill_ff <= fill_in;
         step_ff <= step_in;
      end
   end

   // Block buffer; a word's first byte clears the rest of the word.
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         case (fill_ff[1:0])
            2'd0: block_ff[fill_ff[5:2]] <= {24'd0, cmd.put_byte};
            2'd1: block_ff[fill_ff[5:2]][15:8] <= cmd.put_byte;
            2'd2: block_ff[fill_ff[5:2]][23:16] <= cmd.put_byte;
            default: block_ff[fill_ff[5:2]][31:24] <= cmd.put_byte;
         endcase
      end
      if (cmd.put_length) begin
         block_ff[14] <= bits[31:0];
         block_ff[15] <= bits[63:32];
      end
   end

   assign status.fill = fill_ff;
   assign status.step = step_ff;
   assign chain_a = ca_ff;
   assign chain_b = cb_ff;
   assign chain_c = cc_ff;
   assign chain_d = cd_ff;

endmodule

// File: sv/md5_control.sv
// ----------------------------------------------------------------------------
// md5_control
// Sequencer: byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module md5_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_valid,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          out_index,
   output md5_pkg::cmd_type    cmd,
   input  md5_pkg::status_type status
);

   md5_pkg::state_type state_ff, state_in;
   logic pad_ff, pad_in;   // message ended; padding owed
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         pad_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         pad_ff <= pad_in;
         idx_ff <= idx_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      pad_in = pad_ff;
      idx_in = idx_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.put = req_byte_valid;
               cmd.put_byte = req_data_byte;
               cmd.count = req_byte_valid;
               pad_in = req_last;
               if (req_byte_valid && status.fill == 6'd63) begin
                  cmd.load_work = 1'b1;
                  state_in = md5_pkg::ST_ROUND;
               end else if (req_last) begin
                  state_in = md5_pkg::ST_PAD;
                  idx_in = 2'd0; // marks the pad byte as still owed
               end
            end
         end
         md5_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.step == 6'd63) begin
               state_in = md5_pkg::ST_FOLD;
            end
         end
         md5_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!pad_ff) begin
               state_in = md5_pkg::ST_IDLE;
            end else if (idx_ff == 2'd3) begin
               state_in = md5_pkg::ST_OUT;
               idx_in = 2'd0;
            end else begin
               state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_PAD: begin
            // idx 0: put 0x80; idx 1: zero fill; then length and last block.
            if (idx_ff == 2'd0) begin
               cmd.put = 1'b1;
               cmd.put_byte = md5_pkg::PadByte;
               idx_in = 2'd1;
               if (status.fill == 6'd63) begin
                  cmd.load_work = 1'b1;
                  state_in = md5_pkg::ST_ROUND;
               end
            end else if (status.fill == md5_pkg::LengthFill) begin
               cmd.put_length = 1'b1;
               cmd.load_work = 1'b1;
               idx_in = 2'd3;
               state_in = md5_pkg::ST_ROUND;
            end else begin
               cmd.put = 1'b1;
               if (status.fill == 6'd63) begin
                  cmd.load_work = 1'b1;
                  state_in = md5_pkg::ST_ROUND;
               end
            end
         end
         md5_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  cmd.rearm = 1'b1;
                  pad_in = 1'b0;
                  state_in = md5_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   assign out_index = idx_ff;

`ifndef NO_ASSERTIONS
   a_round_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::ST_ROUND && status.step == 6'd63)
      |=> state_ff == md5_pkg::ST_FOLD)
      else $error("round count overran");
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("output while taking input");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(idx_ff))
      else $error("digest word dropped");
`endif

endmodule

// File: sv/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest of a byte stream, four chaining words out per message.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts one compression (one round per cycle in a
// single round unit), then a fold adds the work words into the chain words.
// The last request adds the padding, written one byte per cycle between
// compressions, and one or two compressions, then four digest words A to D go
// out. The unit takes one byte at a time, none while a block is compressed.
module md5_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   md5_pkg::cmd_type cmd;
   md5_pkg::status_type status;
   logic [31:0] ca, cb, cc, cd;
   logic [1:0] idx;

   md5_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte,
      .req_byte_valid, .req_last, .rsp_valid, .rsp_ready,
      .out_index(idx), .cmd, .status
   );

   md5_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .chain_a(ca), .chain_b(cb), .chain_c(cc), .chain_d(cd)
   );

   // Select the chaining word being delivered.
   always_comb begin
      case (idx)
         2'd0: rsp_digest_word = ca;
         2'd1: rsp_digest_word = cb;
         2'd2: rsp_digest_word = cc;
         default: rsp_digest_word = cd;
      endcase
   end

   assign rsp_word_index = idx;
   assign rsp_digest_last = (idx == 2'd3);

endmodule
